// File: design/pfp_pkg.sv
// Package for the pressure frame parser: state codes, character codes and
// the result record shared by the step logic and the top level.
// No dependencies.
package pfp_pkg;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_M2   = 4'd2;
  localparam logic [3:0] ST_M3   = 4'd3;
  localparam logic [3:0] ST_SEP  = 4'd4;
  localparam logic [3:0] ST_L1   = 4'd5;
  localparam logic [3:0] ST_L2   = 4'd6;
  localparam logic [3:0] ST_L3   = 4'd7;
  localparam logic [3:0] ST_LAST = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;
  localparam logic [3:0] ST_ERR  = 4'd10;

  localparam logic [7:0] CH_START = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_END   = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [3:0] parse_state;
    logic       write_enable;
    logic [2:0] write_index;
    logic [7:0] write_char;
    logic [2:0] next_index;
  } pfp_step_t;

endpackage

// File: design/pfp_in_if.sv
// Input channel of the pressure frame parser: one received byte per beat.
// No dependencies.
interface pfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/pfp_out_if.sv
// Result channel of the pressure frame parser: new state and buffer write.
// No dependencies.
interface pfp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] parse_state;
  logic       write_enable;
  logic [2:0] write_index;
  logic [7:0] write_char;

  modport source (output valid, output parse_state, output write_enable,
                  output write_index, output write_char, input ready);
  modport sink (input valid, input parse_state, input write_enable,
                input write_index, input write_char, output ready);
endinterface

// File: design/pfp_step.sv
// Next-state and buffer-write logic of the frame parser for one byte.
// Depends on pfp_pkg.
module pfp_step
  import pfp_pkg::*;
(
  input  logic [3:0] cur_state,
  input  logic [2:0] cur_index,
  input  logic [7:0] rx_byte,
  output pfp_step_t  step
);

  logic dig;
  logic is_x;
  logic is_end;
  logic wr;
  logic [3:0] nxt;
  logic [7:0] wchar;

  assign dig    = rx_byte inside {[CH_ZERO:CH_NINE]};
  assign is_x   = (rx_byte == CH_X);
  assign is_end = (rx_byte == CH_END);

  always_comb begin
    wr    = 1'b1;
    wchar = rx_byte;
    case (cur_state)
      ST_M1:   nxt = dig ? ST_M2 : ST_ERR;
      ST_M2:   nxt = dig ? ST_M3 : (is_x ? ST_L1 : ST_ERR);
      ST_M3:   nxt = dig ? ST_SEP : (is_x ? ST_L1 : ST_ERR);
      ST_SEP:  nxt = is_x ? ST_L1 : ST_ERR;
      ST_L1:   nxt = dig ? ST_L2 : ST_ERR;
      ST_L2: begin
        nxt   = dig ? ST_L3 : (is_end ? ST_DONE : ST_ERR);
        wchar = dig ? rx_byte : CH_SPACE;
      end
      ST_L3: begin
        nxt   = dig ? ST_LAST : (is_end ? ST_DONE : ST_ERR);
        wchar = dig ? rx_byte : CH_SPACE;
      end
      ST_LAST: begin
        nxt = is_end ? ST_DONE : ST_ERR;
        wr  = 1'b0;
      end
      default: begin
        nxt = (rx_byte == CH_START) ? ST_M1 : ST_ERR;
        wr  = 1'b0;
      end
    endcase
  end

  always_comb begin
    step.parse_state  = nxt;
    step.write_enable = wr;
    step.write_index  = wr ? cur_index : 3'd0;
    step.write_char   = wr ? wchar : 8'd0;
    if (wr) begin
      step.next_index = cur_index + 3'd1;
    end else if (cur_state == ST_LAST) begin
      step.next_index = cur_index;
    end else begin
      step.next_index = 3'd0;
    end
  end

endmodule

// File: design/pressure_frame_parser_core.sv
// Pressure frame parser top level: parser state, write index, result register.
// Depends on pfp_pkg, pfp_in_if, pfp_out_if and pfp_step.
// Result register: a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver takes results; the single
// result register refills in the cycle its beat is taken.
// Reset (synchronous, rst_n low): state idle, write index 0, no result held.
module pressure_frame_parser_core
  import pfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pfp_in_if.sink    in_ch,
  pfp_out_if.source out_ch
);

  logic [3:0] state_r;
  logic [2:0] index_r;
  logic       out_valid_r;
  logic [3:0] out_state_r;
  logic       out_we_r;
  logic [2:0] out_index_r;
  logic [7:0] out_char_r;
  logic       accept;
  pfp_step_t  step;

  pfp_step u_step (
    .cur_state (state_r),
    .cur_index (index_r),
    .rx_byte   (in_ch.rx_byte),
    .step      (step)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      index_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= step.parse_state;
        index_r     <= step.next_index;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_state_r <= step.parse_state;
      out_we_r    <= step.write_enable;
      out_index_r <= step.write_index;
      out_char_r  <= step.write_char;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parse_state  = out_state_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.write_index  = out_index_r;
  assign out_ch.write_char   = out_char_r;

endmodule

// File: tb/tb_pressure_frame_parser_core.sv
// Testbench for pressure_frame_parser_core: frame-shaped and noisy byte streams
// with bursty input and a stalling receiver, checked against a byte-level predictor.
// Depends on pfp_pkg, pfp_in_if, pfp_out_if and the core.
module tb_pressure_frame_parser_core;
  import pfp_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [3:0] parse_state;
    logic       write_enable;
    logic [2:0] write_index;
    logic [7:0] write_char;
  } parse_result_t;

  typedef enum {RX_STEADY, RX_COIN, RX_THIRDS, RX_MOSTLY} rx_pattern_t;

  class frame_scoreboard;
    logic [3:0] cur_state;
    logic [2:0] buf_pos;
    parse_result_t pending_results[$];
    int failures;

    function new();
      cur_state = ST_IDLE;
      buf_pos = '0;
      failures = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      parse_result_t r;
      logic dig;
      logic wr;
      logic [7:0] ch;
      logic [3:0] nxt;
      dig = (b >= CH_ZERO) && (b <= CH_NINE);
      wr = 1'b0;
      ch = b;
      case (cur_state)
        ST_M1: begin
          nxt = dig ? ST_M2 : ST_ERR;
          wr = 1'b1;
        end
        ST_M2: begin
          nxt = dig ? ST_M3 : (b == CH_X ? ST_L1 : ST_ERR);
          wr = 1'b1;
        end
        ST_M3: begin
          nxt = dig ? ST_SEP : (b == CH_X ? ST_L1 : ST_ERR);
          wr = 1'b1;
        end
        ST_SEP: begin
          nxt = (b == CH_X) ? ST_L1 : ST_ERR;
          wr = 1'b1;
        end
        ST_L1: begin
          nxt = dig ? ST_L2 : ST_ERR;
          wr = 1'b1;
        end
        ST_L2: begin
          nxt = dig ? ST_L3 : (b == CH_END ? ST_DONE : ST_ERR);
          wr = 1'b1;
          ch = dig ? b : CH_SPACE;
        end
        ST_L3: begin
          nxt = dig ? ST_LAST : (b == CH_END ? ST_DONE : ST_ERR);
          wr = 1'b1;
          ch = dig ? b : CH_SPACE;
        end
        ST_LAST: begin
          nxt = (b == CH_END) ? ST_DONE : ST_ERR;
        end
        default: begin
          nxt = (b == CH_START) ? ST_M1 : ST_ERR;
          buf_pos = '0;
        end
      endcase
      r.parse_state = nxt;
      r.write_enable = wr;
      r.write_index = wr ? buf_pos : 3'd0;
      r.write_char = wr ? ch : 8'd0;
      pending_results.push_back(r);
      if (wr) buf_pos = buf_pos + 3'd1;
      cur_state = nxt;
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: state %0d we %0b idx %0d char %02h",
                   got.parse_state, got.write_enable, got.write_index,
                   got.write_char);
        return;
      end
      want = pending_results.pop_front();
      if (got.parse_state !== want.parse_state || got.write_enable !== want.write_enable ||
          got.write_index !== want.write_index || got.write_char !== want.write_char) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: expected state %0d we %0b idx %0d char %02h, ",
                    "got state %0d we %0b idx %0d char %02h"},
                   want.parse_state, want.write_enable, want.write_index, want.write_char,
                   got.parse_state, got.write_enable, got.write_index, got.write_char);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  frame_scoreboard sb;

  pfp_in_if in_ch();
  pfp_out_if out_ch();

  pressure_frame_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver: stall patterns plus one long hold-off
  initial begin
    rx_pattern_t mode;
    int mode_left;
    int hold_left;
    int phase;
    int beats;
    bit held;
    mode = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    beats = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.parse_state, out_ch.write_enable,
                         out_ch.write_index, out_ch.write_char});
        beats++;
      end
      if (!held && beats >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = rx_pattern_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_THIRDS: out_ch.ready <= (phase % 3 == 0);
          default:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [7:0] stim[$];
    logic [7:0] frame_q[$];
    int kind;
    int n;
    int cut;
    int i;
    int burst;
    int gap;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;

    stim = {8'h00, 8'hff, CH_START, CH_ZERO, CH_NINE, CH_NINE, CH_X,
            CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_ZERO + 8'd3, CH_END,
            CH_START, CH_ZERO + 8'd5, CH_X, CH_ZERO + 8'd7, CH_END,
            CH_START, CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_X,
            CH_ZERO + 8'd3, CH_ZERO + 8'd4, CH_END,
            CH_START, 8'h41};

    n = stim.size() + RANDOM_ITEMS;
    while (stim.size() < n) begin
      kind = $urandom_range(0, 9);
      frame_q = {CH_START};
      repeat ($urandom_range(1, 3)) frame_q.push_back(rand_digit());
      frame_q.push_back(CH_X);
      repeat ($urandom_range(1, 3)) frame_q.push_back(rand_digit());
      frame_q.push_back(CH_END);
      if (kind == 7) begin
        frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 8) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        frame_q = frame_q[0:cut - 1];
      end else if (kind == 9) begin
        frame_q.delete();
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (frame_q[k]) stim.push_back(frame_q[k]);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    i = 0;
    while (i < stim.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && i < stim.size()) begin
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= stim[i];
        do @(posedge clk); while (!in_ch.ready);
        sb.note_byte(stim[i]);
        i++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
